// ----- sv/pdrc_pkg.sv -----
// shared types, constants and saturating arithmetic for the depth range clamp
package pdrc_pkg;

    localparam int DEF_FRAC_BITS = 40;
    localparam int QW            = 64;
    localparam int RATIO_W       = 41;
    localparam int MUL_LAT       = 2;
    localparam int DIV_LAT       = QW / 2 + 2;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q SMAX = {1'b0, {(QW-1){1'b1}}};
    localparam t_q SMIN = {1'b1, {(QW-1){1'b0}}};

    // register indexes on the configuration port
    localparam logic [1:0] REG_MIN_NEAR = 2'd0;
    localparam logic [1:0] REG_MAX_FAR  = 2'd1;
    localparam logic [1:0] REG_RATIO    = 2'd2;

    // one request and its working values as it moves down the pipeline
    typedef struct packed {
        logic       inv;
        logic       close;
        logic       ortho;
        t_q         near_in;
        t_q         far_in;
        t_q [3:0]   c2;
        t_q [3:0]   c3;
        t_q         n;
        t_q         f;
        t_q         x0;
        t_q         x1;
        t_q         x2;
        t_q         x3;
    } t_item;

    function automatic logic [QW-1:0] mag(input t_q a);
        mag = a[QW-1] ? QW'(-a) : QW'(a);
    endfunction

    function automatic t_q sadd(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1]) begin
            sadd = s[QW] ? SMIN : SMAX;
        end else begin
            sadd = s[QW-1:0];
        end
    endfunction

    function automatic t_q ssub(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} - {b[QW-1], b};
        if (s[QW] != s[QW-1]) begin
            ssub = s[QW] ? SMIN : SMAX;
        end else begin
            ssub = s[QW-1:0];
        end
    endfunction

    function automatic t_q sneg(input t_q a);
        sneg = (a == SMIN) ? SMAX : -a;
    endfunction

    // floor of the mean, exact over the full range
    function automatic t_q smean(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        smean = s[QW:1];
    endfunction

    // apply sign to a magnitude and saturate
    function automatic t_q pack(input logic neg, input logic ovf, input logic [QW-1:0] lo);
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        lim = neg ? QW'(SMIN) : QW'(SMAX);
        m   = (ovf || lo > lim) ? lim : lo;
        pack = neg ? t_q'(-m) : t_q'(m);
    endfunction

endpackage

// ----- sv/pdrc_mul.sv -----
// two stage fixed point multiplier lanes with saturation and a side tag
module pdrc_mul #(
    parameter int FRAC_BITS = pdrc_pkg::DEF_FRAC_BITS,
    parameter int LANES     = 1,
    parameter int TAG_W     = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [TAG_W-1:0] i_tag,
    input  pdrc_pkg::t_q     i_a [LANES],
    input  pdrc_pkg::t_q     i_b [LANES],
    output logic             o_vld,
    output logic [TAG_W-1:0] o_tag,
    output pdrc_pkg::t_q     o_p [LANES]
);
    localparam int QW = pdrc_pkg::QW;
    localparam int HW = QW / 2;

    logic             r_v1;
    logic [TAG_W-1:0] r_tag1;
    logic             r_neg [LANES];
    logic [QW-1:0]    r_ll [LANES];
    logic [QW-1:0]    r_lh [LANES];
    logic [QW-1:0]    r_hl [LANES];
    logic [QW-1:0]    r_hh [LANES];
    logic             n_neg [LANES];
    logic [QW-1:0]    n_ll [LANES];
    logic [QW-1:0]    n_lh [LANES];
    logic [QW-1:0]    n_hl [LANES];
    logic [QW-1:0]    n_hh [LANES];

    logic             r_v2;
    logic [TAG_W-1:0] r_tag2;
    pdrc_pkg::t_q     r_p [LANES];
    pdrc_pkg::t_q     n_p [LANES];

    // partial products
    always_comb begin
        logic [QW-1:0] xa;
        logic [QW-1:0] xb;
        for (int l = 0; l < LANES; l++) begin
            xa = pdrc_pkg::mag(i_a[l]);
            xb = pdrc_pkg::mag(i_b[l]);
            n_neg[l] = i_a[l][QW-1] ^ i_b[l][QW-1];
            n_ll[l]  = QW'(xa[HW-1:0]) * QW'(xb[HW-1:0]);
            n_lh[l]  = QW'(xa[HW-1:0]) * QW'(xb[QW-1:HW]);
            n_hl[l]  = QW'(xa[QW-1:HW]) * QW'(xb[HW-1:0]);
            n_hh[l]  = QW'(xa[QW-1:HW]) * QW'(xb[QW-1:HW]);
        end
    end

    // sum, drop fraction bits, saturate
    always_comb begin
        logic [2*QW-1:0] full;
        for (int l = 0; l < LANES; l++) begin
            full = {{QW{1'b0}}, r_ll[l]}
                 + ({{QW{1'b0}}, r_lh[l]} << HW)
                 + ({{QW{1'b0}}, r_hl[l]} << HW)
                 + {r_hh[l], {QW{1'b0}}};
            n_p[l] = pdrc_pkg::pack(r_neg[l], |full[2*QW-1:FRAC_BITS+QW],
                                    full[FRAC_BITS +: QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
        r_tag1 <= i_tag;
        r_tag2 <= r_tag1;
        for (int l = 0; l < LANES; l++) begin
            r_neg[l] <= n_neg[l];
            r_ll[l]  <= n_ll[l];
            r_lh[l]  <= n_lh[l];
            r_hl[l]  <= n_hl[l];
            r_hh[l]  <= n_hh[l];
            r_p[l]   <= n_p[l];
        end
    end

    assign o_vld = r_v2;
    assign o_tag = r_tag2;
    assign o_p   = r_p;

endmodule

// ----- sv/pdrc_div.sv -----
// pipelined restoring fixed point divider lanes, two quotient bits per stage
module pdrc_div #(
    parameter int FRAC_BITS = pdrc_pkg::DEF_FRAC_BITS,
    parameter int LANES     = 1,
    parameter int TAG_W     = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [TAG_W-1:0] i_tag,
    input  pdrc_pkg::t_q     i_a [LANES],
    input  pdrc_pkg::t_q     i_b [LANES],
    output logic             o_vld,
    output logic [TAG_W-1:0] o_tag,
    output pdrc_pkg::t_q     o_q [LANES]
);
    localparam int QW   = pdrc_pkg::QW;
    localparam int STEP = 2;
    localparam int STG  = QW / STEP;

    logic             r_v   [STG+1];
    logic [TAG_W-1:0] r_tag [STG+1];
    logic [QW-1:0]    r_r   [STG+1][LANES];
    logic [QW-1:0]    r_n   [STG+1][LANES];
    logic [QW-1:0]    r_qt  [STG+1][LANES];
    logic [QW-1:0]    r_d   [STG+1][LANES];
    logic             r_neg [STG+1][LANES];
    logic             r_ovf [STG+1][LANES];
    logic             r_dz  [STG+1][LANES];
    pdrc_pkg::t_q     r_dzv [STG+1][LANES];

    logic             r_vo;
    logic [TAG_W-1:0] r_tago;
    pdrc_pkg::t_q     r_q [LANES];

    // set-up: magnitudes, high half of the shifted dividend, overflow and zero divisor
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] x;
        logic [QW-1:0] d;
        logic [QW-1:0] nh;
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
        end
        r_tag[0] <= i_tag;
        for (int l = 0; l < LANES; l++) begin
            x  = pdrc_pkg::mag(i_a[l]);
            d  = pdrc_pkg::mag(i_b[l]);
            nh = x >> (QW - FRAC_BITS);
            r_r[0][l]   <= nh;
            r_n[0][l]   <= x << FRAC_BITS;
            r_qt[0][l]  <= '0;
            r_d[0][l]   <= d;
            r_neg[0][l] <= i_a[l][QW-1] ^ i_b[l][QW-1];
            r_ovf[0][l] <= nh >= d;
            r_dz[0][l]  <= d == '0;
            r_dzv[0][l] <= (i_a[l] == '0) ? '0 :
                           (i_a[l][QW-1] ? pdrc_pkg::SMIN : pdrc_pkg::SMAX);
        end
    end

    for (genvar s = 0; s < STG; s++) begin : g_stage
        logic [QW-1:0] n_r  [LANES];
        logic [QW-1:0] n_n  [LANES];
        logic [QW-1:0] n_qt [LANES];

        always_comb begin
            logic [QW-1:0] rr;
            logic [QW-1:0] nn;
            logic [QW-1:0] qq;
            logic [QW:0]   rem;
            for (int l = 0; l < LANES; l++) begin
                rr = r_r[s][l];
                nn = r_n[s][l];
                qq = r_qt[s][l];
                for (int k = 0; k < STEP; k++) begin
                    rem = {rr, nn[QW-1]};
                    nn  = nn << 1;
                    if (rem >= {1'b0, r_d[s][l]}) begin
                        rem = rem - {1'b0, r_d[s][l]};
                        qq  = {qq[QW-2:0], 1'b1};
                    end else begin
                        qq  = {qq[QW-2:0], 1'b0};
                    end
                    rr = rem[QW-1:0];
                end
                n_r[l]  = rr;
                n_n[l]  = nn;
                n_qt[l] = qq;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_tag[s+1] <= r_tag[s];
            for (int l = 0; l < LANES; l++) begin
                r_r[s+1][l]   <= n_r[l];
                r_n[s+1][l]   <= n_n[l];
                r_qt[s+1][l]  <= n_qt[l];
                r_d[s+1][l]   <= r_d[s][l];
                r_neg[s+1][l] <= r_neg[s][l];
                r_ovf[s+1][l] <= r_ovf[s][l];
                r_dz[s+1][l]  <= r_dz[s][l];
                r_dzv[s+1][l] <= r_dzv[s][l];
            end
        end
    end

    // sign and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[STG];
        end
        r_tago <= r_tag[STG];
        for (int l = 0; l < LANES; l++) begin
            r_q[l] <= r_dz[STG][l] ? r_dzv[STG][l] :
                      pdrc_pkg::pack(r_neg[STG][l], r_ovf[STG][l], r_qt[STG][l]);
        end
    end

    assign o_vld = r_vo;
    assign o_tag = r_tago;
    assign o_q   = r_q;

endmodule

// ----- sv/projection_depth_range_clamp.sv -----
// top level: near/far depth clamp and projection column 2 rewrite, fully pipelined
//
// usage
//   a request carries a near/far pair and columns 2 and 3 of a projection matrix,
//   all signed fixed point with FRAC_BITS fraction bits (Q24.40 by default)
//   a request is taken on a rising edge with start high and busy low; busy is
//   always low, so a new request may follow on every cycle
//   each request gives exactly one result, shown for one cycle with o_valid high;
//   results leave in request order and the receiver cannot hold them off
//   the result path runs through two chained pipelined dividers of 34 stages
//   each plus four two-stage multiplier banks
//   throughput is one request per cycle
//   min_near, max_far and near_far_ratio sit on an APB-style port at byte
//   addresses 0, 8 and 16; writes complete in the access cycle, reads return
//   the register; write only when no request is in flight
//   synchronous reset clears every valid bit in the pipeline, so requests in
//   flight are dropped, and loads the register reset values
//   o_applied low marks a depth range that could not be used; the inputs then
//   come back unchanged
module projection_depth_range_clamp #(
    parameter int FRAC_BITS = pdrc_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [pdrc_pkg::QW-1:0] i_near_in,
    input  logic signed [pdrc_pkg::QW-1:0] i_far_in,
    input  logic signed [pdrc_pkg::QW-1:0] i_col2_row0,
    input  logic signed [pdrc_pkg::QW-1:0] i_col2_row1,
    input  logic signed [pdrc_pkg::QW-1:0] i_col2_row2,
    input  logic signed [pdrc_pkg::QW-1:0] i_col2_row3,
    input  logic signed [pdrc_pkg::QW-1:0] i_col3_row0,
    input  logic signed [pdrc_pkg::QW-1:0] i_col3_row1,
    input  logic signed [pdrc_pkg::QW-1:0] i_col3_row2,
    input  logic signed [pdrc_pkg::QW-1:0] i_col3_row3,
    // result channel
    output logic                          o_valid,
    output logic                          o_applied,
    output logic signed [pdrc_pkg::QW-1:0] o_near_out,
    output logic signed [pdrc_pkg::QW-1:0] o_far_out,
    output logic signed [pdrc_pkg::QW-1:0] o_new_col2_row0,
    output logic signed [pdrc_pkg::QW-1:0] o_new_col2_row1,
    output logic signed [pdrc_pkg::QW-1:0] o_new_col2_row2,
    output logic signed [pdrc_pkg::QW-1:0] o_new_col2_row3,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    localparam int QW    = pdrc_pkg::QW;
    localparam int TW    = $bits(pdrc_pkg::t_item);
    localparam int LAT   = 12 + 4 * pdrc_pkg::MUL_LAT + 2 * pdrc_pkg::DIV_LAT;

    // fixed point constants, rounded to nearest
    localparam pdrc_pkg::t_q ONE   = pdrc_pkg::t_q'(64'sd1 <<< FRAC_BITS);
    localparam pdrc_pkg::t_q EPS_R = (ONE + 64'sd500000) / 64'sd1000000;
    localparam pdrc_pkg::t_q EPS   = (EPS_R < 64'sd1) ? 64'sd1 : EPS_R;
    localparam logic [QW-1:0] EPS_U = QW'(EPS);
    localparam pdrc_pkg::t_q K02   = (ONE * 64'sd2 + 64'sd50) / 64'sd100;
    localparam pdrc_pkg::t_q K98   = (ONE * 64'sd98 + 64'sd50) / 64'sd100;
    localparam pdrc_pkg::t_q K102  = (ONE * 64'sd102 + 64'sd50) / 64'sd100;

    // configuration registers
    pdrc_pkg::t_q               r_min_near;
    pdrc_pkg::t_q               r_max_far;
    logic [pdrc_pkg::RATIO_W-1:0] r_ratio;

    logic wr_en;
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_near <= pdrc_pkg::SMIN;
            r_max_far  <= pdrc_pkg::SMAX;
            r_ratio    <= pdrc_pkg::RATIO_W'(164926744);
        end else if (wr_en) begin
            case (paddr[4:3])
                pdrc_pkg::REG_MIN_NEAR: r_min_near <= pwdata;
                pdrc_pkg::REG_MAX_FAR:  r_max_far  <= pwdata;
                pdrc_pkg::REG_RATIO:    r_ratio    <= pwdata[pdrc_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            pdrc_pkg::REG_MIN_NEAR: prdata = r_min_near;
            pdrc_pkg::REG_MAX_FAR:  prdata = r_max_far;
            pdrc_pkg::REG_RATIO:    prdata = {{(64-pdrc_pkg::RATIO_W){1'b0}}, r_ratio};
            default:                prdata = '0;
        endcase
    end

    // pipeline stage registers
    logic            r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11;
    pdrc_pkg::t_item r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9, r_s10, r_s11;
    pdrc_pkg::t_item n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9, n_s10, n_s11;

    // arithmetic units
    logic            m1_v, m2_v, m3_v, m4_v, d1_v, d2_v;
    logic [TW-1:0]   m1_t, m2_t, m3_t, m4_t, d1_t, d2_t;
    pdrc_pkg::t_item m1_i, m2_i, m3_i, m4_i, d1_i, d2_i;
    pdrc_pkg::t_q    m1_a [3], m1_b [3], m1_p [3];
    pdrc_pkg::t_q    m2_a [4], m2_b [4], m2_p [4];
    pdrc_pkg::t_q    m3_a [1], m3_b [1], m3_p [1];
    pdrc_pkg::t_q    m4_a [8], m4_b [8], m4_p [8];
    pdrc_pkg::t_q    d1_a [2], d1_b [2], d1_q [2];
    pdrc_pkg::t_q    d2_a [1], d2_b [1], d2_q [1];

    assign m1_i = m1_t;
    assign m2_i = m2_t;
    assign m3_i = m3_t;
    assign m4_i = m4_t;
    assign d1_i = d1_t;
    assign d2_i = d2_t;

    // capture the request
    always_comb begin
        n_s1         = '0;
        n_s1.near_in = i_near_in;
        n_s1.far_in  = i_far_in;
        n_s1.c2      = {i_col2_row3, i_col2_row2, i_col2_row1, i_col2_row0};
        n_s1.c3      = {i_col3_row3, i_col3_row2, i_col3_row1, i_col3_row0};
    end

    // apply the configured bounds
    always_comb begin
        n_s2   = r_s1;
        n_s2.n = (r_s1.near_in > r_min_near) ? r_s1.near_in : r_min_near;
        n_s2.f = (r_s1.far_in < r_max_far) ? r_s1.far_in : r_max_far;
    end

    // range checks, mean for a close pair, orthographic test on column 3
    always_comb begin
        n_s3       = r_s2;
        n_s3.inv   = r_s2.f < pdrc_pkg::ssub(r_s2.n, EPS);
        n_s3.close = r_s2.f < pdrc_pkg::sadd(r_s2.n, EPS);
        n_s3.x0    = pdrc_pkg::smean(r_s2.n, r_s2.f);
        n_s3.ortho = (pdrc_pkg::mag(r_s2.c3[0]) < EPS_U) &&
                     (pdrc_pkg::mag(r_s2.c3[1]) < EPS_U) &&
                     (pdrc_pkg::mag(r_s2.c3[2]) < EPS_U);
    end

    // widen a close pair about its mean
    always_comb begin
        n_s4 = r_s3;
        if (r_s3.close) begin
            n_s4.n = pdrc_pkg::ssub(r_s3.x0, EPS);
            n_s4.f = pdrc_pkg::sadd(r_s3.x0, EPS);
        end
    end

    // span for the orthographic padding
    always_comb begin
        n_s5    = r_s4;
        n_s5.x0 = pdrc_pkg::ssub(r_s4.f, r_s4.n);
    end

    // padding or near pull / far push / near limit products
    assign m1_a[0] = r_s5.ortho ? r_s5.x0 : r_s5.n;
    assign m1_b[0] = r_s5.ortho ? K02 : K98;
    assign m1_a[1] = r_s5.f;
    assign m1_b[1] = K102;
    assign m1_a[2] = r_s5.f;
    assign m1_b[2] = {{(QW-pdrc_pkg::RATIO_W){1'b0}}, r_ratio};

    pdrc_mul #(.FRAC_BITS(FRAC_BITS), .LANES(3), .TAG_W(TW)) u_mul1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v5), .i_tag(r_s5),
        .i_a(m1_a), .i_b(m1_b), .o_vld(m1_v), .o_tag(m1_t), .o_p(m1_p)
    );

    // new near and far
    always_comb begin
        pdrc_pkg::t_q d;
        pdrc_pkg::t_q dn;
        n_s6 = m1_i;
        d    = (m1_p[0] < ONE) ? ONE : m1_p[0];
        dn   = (m1_p[0] < m1_p[2]) ? m1_p[2] : m1_p[0];
        if (m1_i.ortho) begin
            n_s6.n = pdrc_pkg::ssub(m1_i.n, d);
            n_s6.f = pdrc_pkg::sadd(m1_i.f, d);
        end else begin
            n_s6.n = (dn < ONE) ? ONE : dn;
            n_s6.f = m1_p[1];
        end
    end

    // z times rows 2 of columns 2 and 3 at near and far
    assign m2_a[0] = r_s6.n;
    assign m2_b[0] = r_s6.c2[2];
    assign m2_a[1] = r_s6.n;
    assign m2_b[1] = r_s6.c3[2];
    assign m2_a[2] = r_s6.f;
    assign m2_b[2] = r_s6.c2[2];
    assign m2_a[3] = r_s6.f;
    assign m2_b[3] = r_s6.c3[2];

    pdrc_mul #(.FRAC_BITS(FRAC_BITS), .LANES(4), .TAG_W(TW)) u_mul2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v6), .i_tag(r_s6),
        .i_a(m2_a), .i_b(m2_b), .o_vld(m2_v), .o_tag(m2_t), .o_p(m2_p)
    );

    // dividends and divisors: plane depths, or the orthographic row 2 and row 3
    always_comb begin
        pdrc_pkg::t_q span;
        n_s7 = m2_i;
        span = pdrc_pkg::ssub(m2_i.f, m2_i.n);
        if (m2_i.ortho) begin
            n_s7.x0 = pdrc_pkg::sneg(pdrc_pkg::sadd(ONE, ONE));
            n_s7.x1 = span;
            n_s7.x2 = pdrc_pkg::sadd(m2_i.f, m2_i.n);
            n_s7.x3 = span;
        end else begin
            n_s7.x0 = pdrc_pkg::ssub(m2_i.c2[3], m2_p[0]);
            n_s7.x1 = pdrc_pkg::ssub(m2_i.c3[3], m2_p[1]);
            n_s7.x2 = pdrc_pkg::ssub(m2_i.c2[3], m2_p[2]);
            n_s7.x3 = pdrc_pkg::ssub(m2_i.c3[3], m2_p[3]);
        end
    end

    assign d1_a[0] = r_s7.x0;
    assign d1_b[0] = r_s7.x1;
    assign d1_a[1] = r_s7.x2;
    assign d1_b[1] = r_s7.x3;

    pdrc_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_W(TW)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v7), .i_tag(r_s7),
        .i_a(d1_a), .i_b(d1_b), .o_vld(d1_v), .o_tag(d1_t), .o_q(d1_q)
    );

    // orthographic rows done here; perspective takes the difference and centre
    always_comb begin
        n_s8    = d1_i;
        n_s8.x0 = pdrc_pkg::ssub(d1_q[0], d1_q[1]);
        n_s8.x1 = pdrc_pkg::sneg(pdrc_pkg::smean(d1_q[0], d1_q[1]));
        if (d1_i.ortho && !d1_i.inv) begin
            n_s8.c2[2] = d1_q[0];
            n_s8.c2[3] = pdrc_pkg::sneg(d1_q[1]);
        end
    end

    assign d2_a[0] = pdrc_pkg::sadd(ONE, ONE);
    assign d2_b[0] = r_s8.x0;

    pdrc_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_W(TW)) u_div2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v8), .i_tag(r_s8),
        .i_a(d2_a), .i_b(d2_b), .o_vld(d2_v), .o_tag(d2_t), .o_q(d2_q)
    );

    // remap ratio, made positive
    always_comb begin
        n_s9    = d2_i;
        n_s9.x2 = d2_q[0][QW-1] ? pdrc_pkg::sneg(d2_q[0]) : d2_q[0];
    end

    assign m3_a[0] = r_s9.x1;
    assign m3_b[0] = r_s9.x2;

    pdrc_mul #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_W(TW)) u_mul3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v9), .i_tag(r_s9),
        .i_a(m3_a), .i_b(m3_b), .o_vld(m3_v), .o_tag(m3_t), .o_p(m3_p)
    );

    always_comb begin
        n_s10    = m3_i;
        n_s10.x3 = m3_p[0];
    end

    // column 2 times ratio and column 3 times centre ratio
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m4_a[i]     = r_s10.c2[i];
            m4_b[i]     = r_s10.x2;
            m4_a[i + 4] = r_s10.c3[i];
            m4_b[i + 4] = r_s10.x3;
        end
    end

    pdrc_mul #(.FRAC_BITS(FRAC_BITS), .LANES(8), .TAG_W(TW)) u_mul4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v10), .i_tag(r_s10),
        .i_a(m4_a), .i_b(m4_b), .o_vld(m4_v), .o_tag(m4_t), .o_p(m4_p)
    );

    always_comb begin
        n_s11 = m4_i;
        if (!m4_i.inv && !m4_i.ortho) begin
            for (int i = 0; i < 4; i++) begin
                n_s11.c2[i] = pdrc_pkg::sadd(m4_p[i], m4_p[i + 4]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else begin
            r_v1  <= start && !busy;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= m1_v;
            r_v7  <= m2_v;
            r_v8  <= d1_v;
            r_v9  <= d2_v;
            r_v10 <= m3_v;
            r_v11 <= m4_v;
        end
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        r_s5  <= n_s5;
        r_s6  <= n_s6;
        r_s7  <= n_s7;
        r_s8  <= n_s8;
        r_s9  <= n_s9;
        r_s10 <= n_s10;
        r_s11 <= n_s11;
    end

    // result register; a rejected range returns the request unchanged
    logic         r_valid;
    logic         r_applied;
    logic         r_ortho;
    pdrc_pkg::t_q r_near;
    pdrc_pkg::t_q r_far;
    pdrc_pkg::t_q r_col [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_v11;
        end
        r_applied <= !r_s11.inv;
        r_ortho   <= r_s11.ortho;
        r_near    <= r_s11.inv ? r_s11.near_in : r_s11.n;
        r_far     <= r_s11.inv ? r_s11.far_in : r_s11.f;
        for (int i = 0; i < 4; i++) begin
            r_col[i] <= r_s11.c2[i];
        end
    end

    assign o_valid         = r_valid;
    assign o_applied       = r_applied;
    assign o_near_out      = r_near;
    assign o_far_out       = r_far;
    assign o_new_col2_row0 = r_col[0];
    assign o_new_col2_row1 = r_col[1];
    assign o_new_col2_row2 = r_col[2];
    assign o_new_col2_row3 = r_col[3];

    // every request taken is followed by its result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing at fixed latency");

    // a rejected range hands back the near value it was given
    a_reject_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_applied) |-> (o_near_out == $past(i_near_in, LAT)))
        else $error("rejected range altered near");

    // orthographic rows 0 and 1 pass through untouched; row 0 is checked here
    a_ortho_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_applied && r_ortho) |->
        (o_new_col2_row0 == $past(i_col2_row0, LAT)))
        else $error("orthographic row 0 changed");

endmodule

// ----- dv/pdrc_checker.sv -----
// result checker for the depth range clamp: request capture, prediction and comparison
module pdrc_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  pdrc_pkg::t_q          i_near_in,
    input  pdrc_pkg::t_q          i_far_in,
    input  pdrc_pkg::t_q [3:0]    i_col2,
    input  pdrc_pkg::t_q [3:0]    i_col3,
    input  logic                  o_valid,
    input  logic                  o_applied,
    input  pdrc_pkg::t_q          o_near_out,
    input  pdrc_pkg::t_q          o_far_out,
    input  pdrc_pkg::t_q [3:0]    o_new_col2,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_rejected
);

    localparam int     QW    = pdrc_pkg::QW;
    localparam int     RW    = pdrc_pkg::RATIO_W;
    localparam int     FB    = pdrc_pkg::DEF_FRAC_BITS;
    localparam longint ONE   = longint'(1) << FB;
    localparam longint EPS_R = (ONE + 500000) / 1000000;
    localparam longint EPS   = (EPS_R < 1) ? 1 : EPS_R;
    localparam longint K02   = (ONE * 2 + 50) / 100;
    localparam longint K98   = (ONE * 98 + 50) / 100;
    localparam longint K102  = (ONE * 102 + 50) / 100;
    localparam logic [RW-1:0] RATIO_RST = 41'd164926744;

    typedef struct packed {
        logic                   applied;
        pdrc_pkg::t_q           near_v;
        pdrc_pkg::t_q           far_v;
        pdrc_pkg::t_q [3:0]     col2;
    } t_clamp_res;

    pdrc_pkg::t_q       lo_bound;
    pdrc_pkg::t_q       hi_bound;
    logic [RW-1:0]      ratio_min;
    t_clamp_res         clamp_due[$];
    int                 n_fail;
    int                 n_checked;
    int                 n_rejected;

    function automatic pdrc_pkg::t_q q_add(input pdrc_pkg::t_q a, input pdrc_pkg::t_q b);
        logic signed [QW:0] s;
        s = $signed({a[QW-1], a}) + $signed({b[QW-1], b});
        if (s > $signed({1'b0, pdrc_pkg::SMAX})) return pdrc_pkg::SMAX;
        if (s < $signed({1'b1, pdrc_pkg::SMIN})) return pdrc_pkg::SMIN;
        return s[QW-1:0];
    endfunction

    function automatic pdrc_pkg::t_q q_neg(input pdrc_pkg::t_q a);
        return (a == pdrc_pkg::SMIN) ? pdrc_pkg::SMAX : -a;
    endfunction

    function automatic pdrc_pkg::t_q q_sub(input pdrc_pkg::t_q a, input pdrc_pkg::t_q b);
        logic signed [QW:0] s;
        s = $signed({a[QW-1], a}) - $signed({b[QW-1], b});
        if (s > $signed({1'b0, pdrc_pkg::SMAX})) return pdrc_pkg::SMAX;
        if (s < $signed({1'b1, pdrc_pkg::SMIN})) return pdrc_pkg::SMIN;
        return s[QW-1:0];
    endfunction

    function automatic pdrc_pkg::t_q q_mean(input pdrc_pkg::t_q a, input pdrc_pkg::t_q b);
        logic signed [QW:0] s;
        s = $signed({a[QW-1], a}) + $signed({b[QW-1], b});
        return s[QW:1];
    endfunction

    function automatic logic [QW-1:0] q_abs(input pdrc_pkg::t_q a);
        return a[QW-1] ? (~a + 1'b1) : a;
    endfunction

    // signed result from a sign and a wide magnitude, saturating
    function automatic pdrc_pkg::t_q q_sat(input logic neg, input logic [127:0] m);
        logic [127:0] lim;
        lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (m > lim) m = lim;
        return neg ? pdrc_pkg::t_q'(-m[QW-1:0]) : pdrc_pkg::t_q'(m[QW-1:0]);
    endfunction

    function automatic pdrc_pkg::t_q q_mul(input pdrc_pkg::t_q a, input pdrc_pkg::t_q b);
        logic [127:0] p;
        p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
        return q_sat(a[QW-1] ^ b[QW-1], p >> FB);
    endfunction

    function automatic pdrc_pkg::t_q q_div(input pdrc_pkg::t_q a, input pdrc_pkg::t_q b);
        logic [127:0] num;
        logic [127:0] quo;
        if (b == 0) begin
            return (a > 0) ? pdrc_pkg::SMAX : ((a < 0) ? pdrc_pkg::SMIN : pdrc_pkg::t_q'(0));
        end
        num = {64'd0, q_abs(a)} << FB;
        quo = num / {64'd0, q_abs(b)};
        return q_sat(a[QW-1] ^ b[QW-1], quo);
    endfunction

    // clip-space depth of the plane at distance z
    function automatic pdrc_pkg::t_q plane_depth(input pdrc_pkg::t_q z,
                                                 input pdrc_pkg::t_q [3:0] c2,
                                                 input pdrc_pkg::t_q [3:0] c3);
        return q_div(q_sub(c2[3], q_mul(z, c2[2])), q_sub(c3[3], q_mul(z, c3[2])));
    endfunction

    function automatic t_clamp_res clamp_depth(input pdrc_pkg::t_q nin,
                                               input pdrc_pkg::t_q fin,
                                               input pdrc_pkg::t_q [3:0] c2,
                                               input pdrc_pkg::t_q [3:0] c3);
        t_clamp_res r;
        pdrc_pkg::t_q n, f, m, d, span, dn, df, lim, tn, tf, ratio, centre, cr;
        r.applied = 1'b1;
        r.col2    = c2;
        n = (nin > lo_bound) ? nin : lo_bound;
        f = (fin < hi_bound) ? fin : hi_bound;
        // far well below near: hand everything back untouched
        if (f < q_sub(n, EPS)) begin
            r.applied = 1'b0;
            r.near_v  = nin;
            r.far_v   = fin;
            return r;
        end
        // nearly equal pair, widen about the mean
        if (f < q_add(n, EPS)) begin
            m = q_mean(n, f);
            n = q_sub(m, EPS);
            f = q_add(m, EPS);
        end
        if (q_abs(c3[0]) < 64'(EPS) && q_abs(c3[1]) < 64'(EPS) &&
            q_abs(c3[2]) < 64'(EPS)) begin
            d = q_mul(q_sub(f, n), K02);
            if (d < ONE) d = ONE;
            n = q_sub(n, d);
            f = q_add(f, d);
            span = q_sub(f, n);
            r.col2[2] = q_div(q_neg(q_add(ONE, ONE)), span);
            r.col2[3] = q_neg(q_div(q_add(f, n), span));
        end else begin
            dn  = q_mul(n, K98);
            df  = q_mul(f, K102);
            lim = q_mul(f, pdrc_pkg::t_q'({23'd0, ratio_min}));
            if (dn < lim) dn = lim;
            if (dn < ONE) dn = ONE;
            n  = dn;
            f  = df;
            tn = plane_depth(dn, c2, c3);
            tf = plane_depth(df, c2, c3);
            ratio = q_div(q_add(ONE, ONE), q_sub(tn, tf));
            if (ratio < 0) ratio = q_neg(ratio);
            centre = q_neg(q_mean(tn, tf));
            cr = q_mul(centre, ratio);
            for (int i = 0; i < 4; i++) r.col2[i] = q_add(q_mul(c2[i], ratio), q_mul(c3[i], cr));
        end
        r.near_v = n;
        r.far_v  = f;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_clamp_res want;
        if (!i_rst_n) begin
            lo_bound  <= pdrc_pkg::SMIN;
            hi_bound  <= pdrc_pkg::SMAX;
            ratio_min <= RATIO_RST;
            clamp_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    pdrc_pkg::REG_MIN_NEAR: lo_bound  <= pwdata;
                    pdrc_pkg::REG_MAX_FAR:  hi_bound  <= pwdata;
                    pdrc_pkg::REG_RATIO:    ratio_min <= pwdata[RW-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) clamp_due.push_back(clamp_depth(i_near_in, i_far_in, i_col2, i_col3));
            if (o_valid) begin
                if (clamp_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) $display("unexpected result with nothing outstanding");
                end else begin
                    want = clamp_due.pop_front();
                    n_checked++;
                    if (!want.applied) n_rejected++;
                    if (want !== {o_applied, o_near_out, o_far_out, o_new_col2}) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("mismatch: applied exp %0b got %0b", want.applied, o_applied);
                            $display("  near exp %h got %h, far exp %h got %h",
                                     want.near_v, o_near_out, want.far_v, o_far_out);
                            for (int i = 0; i < 4; i++)
                                $display("  col2 row%0d exp %h got %h", i, want.col2[i], o_new_col2[i]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        n_fail     = 0;
        n_checked  = 0;
        n_rejected = 0;
    end

    assign o_fail_count = n_fail;
    assign o_pending    = clamp_due.size();
    assign o_checked    = n_checked;
    assign o_rejected   = n_rejected;

endmodule

// ----- dv/tb_projection_depth_range_clamp.sv -----
// testbench top for the depth range clamp: stimulus, register settings and verdict
module tb_projection_depth_range_clamp;

    localparam int     QW   = pdrc_pkg::QW;
    localparam longint ONE  = longint'(1) << pdrc_pkg::DEF_FRAC_BITS;
    localparam int     TAIL = 120;    // idle margin after the last result has left the pipeline

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    pdrc_pkg::t_q       near_d, far_d;
    pdrc_pkg::t_q [3:0] col2_d, col3_d;
    logic               o_valid, o_applied;
    pdrc_pkg::t_q       o_near_out, o_far_out;
    pdrc_pkg::t_q [3:0] new_col2;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [63:0]        pwdata, prdata;
    int                 fail_count, pending, checked, rejected;
    int                 sent;
    int                 gap_pct;

    projection_depth_range_clamp i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_near_in(near_d), .i_far_in(far_d),
        .i_col2_row0(col2_d[0]), .i_col2_row1(col2_d[1]),
        .i_col2_row2(col2_d[2]), .i_col2_row3(col2_d[3]),
        .i_col3_row0(col3_d[0]), .i_col3_row1(col3_d[1]),
        .i_col3_row2(col3_d[2]), .i_col3_row3(col3_d[3]),
        .o_valid(o_valid), .o_applied(o_applied),
        .o_near_out(o_near_out), .o_far_out(o_far_out),
        .o_new_col2_row0(new_col2[0]), .o_new_col2_row1(new_col2[1]),
        .o_new_col2_row2(new_col2[2]), .o_new_col2_row3(new_col2[3]),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // checker sits beside the block and only watches
    pdrc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_near_in(near_d), .i_far_in(far_d), .i_col2(col2_d), .i_col3(col3_d),
        .o_valid(o_valid), .o_applied(o_applied), .o_near_out(o_near_out),
        .o_far_out(o_far_out), .o_new_col2(new_col2),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked), .o_rejected(rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // guard against a hung pipeline
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    function automatic pdrc_pkg::t_q rand_raw();
        return {$urandom, $urandom};
    endfunction

    // signed value of magnitude below 2^bits, biased to sensible magnitudes
    function automatic pdrc_pkg::t_q rand_mag(input int bits);
        pdrc_pkg::t_q v;
        v = rand_raw() >> (QW - bits);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // mixed field: full range, extremes, zero, tiny or moderate
    function automatic pdrc_pkg::t_q rand_field();
        case ($urandom_range(0, 5))
            0:       return rand_raw();
            1:       return $urandom_range(0, 1) ? pdrc_pkg::SMAX : pdrc_pkg::SMIN;
            2:       return rand_mag(21);
            3:       return 0;
            default: return rand_mag(44);
        endcase
    endfunction

    // one request, held until the block takes it; then idles with start low for a random gap
    task automatic send(input pdrc_pkg::t_q nv, input pdrc_pkg::t_q fv,
                        input pdrc_pkg::t_q [3:0] c2, input pdrc_pkg::t_q [3:0] c3);
        near_d = nv;
        far_d  = fv;
        col2_d = c2;
        col3_d = c3;
        start  = 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
        @(negedge i_clk);
        while ($urandom_range(1, 100) <= gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = {idx, 3'b000};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);
    endtask

    // a well formed request: plausible depths with a perspective or orthographic matrix
    task automatic send_shaped();
        pdrc_pkg::t_q       n, f;
        pdrc_pkg::t_q [3:0] c2, c3;
        n = pdrc_pkg::t_q'($urandom_range(1, 1000)) * (ONE / 10);
        f = n + pdrc_pkg::t_q'($urandom_range(0, 100000)) * (ONE / 10);
        if ($urandom_range(0, 9) == 0) f = n + rand_mag(20);
        if ($urandom_range(0, 9) == 0) f = n - rand_mag(22);
        for (int i = 0; i < 4; i++) c2[i] = rand_mag(43);
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < 3; i++) c3[i] = rand_mag(20);
            c3[3] = ONE;
        end else begin
            c3[0] = rand_mag(20);
            c3[1] = rand_mag(20);
            c3[2] = $urandom_range(0, 7) ? -ONE : rand_mag(43);
            c3[3] = $urandom_range(0, 3) ? pdrc_pkg::t_q'(0) : rand_mag(42);
        end
        send(n, f, c2, c3);
    endtask

    task automatic send_noise();
        pdrc_pkg::t_q [3:0] c2, c3;
        for (int i = 0; i < 4; i++) begin
            c2[i] = rand_field();
            c3[i] = rand_field();
        end
        send(rand_field(), rand_field(), c2, c3);
    endtask

    task automatic random_phase(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) != 0) send_shaped();
            else send_noise();
        end
    endtask

    initial begin
        pdrc_pkg::t_q [3:0] persp, ortho, zero4, unit;
        i_rst_n = 1'b0;
        start   = 1'b0;
        near_d  = '0;
        far_d   = '0;
        col2_d  = '0;
        col3_d  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sent    = 0;
        gap_pct = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part under the reset register values
        zero4 = '0;
        unit  = {ONE, ONE, ONE, ONE};
        persp = {pdrc_pkg::t_q'(0), -ONE, pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0)};
        ortho = {ONE, pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0)};
        send(ONE, 100 * ONE, unit, persp);                 // ordinary perspective
        send(ONE, 100 * ONE, unit, ortho);                 // ordinary orthographic
        send(10 * ONE, ONE, unit, persp);                  // far well below near, rejected
        send(5 * ONE, 5 * ONE + 3, unit, persp);           // nearly equal pair
        send(5 * ONE, 5 * ONE - 1000, unit, ortho);        // slightly inverted, still close
        send(pdrc_pkg::SMIN, pdrc_pkg::SMAX,
             {pdrc_pkg::SMAX, pdrc_pkg::SMIN, pdrc_pkg::SMAX, pdrc_pkg::SMIN}, persp);
        send(pdrc_pkg::SMAX, pdrc_pkg::SMAX,
             {pdrc_pkg::SMIN, pdrc_pkg::SMAX, pdrc_pkg::SMIN, pdrc_pkg::SMAX}, ortho);
        send(pdrc_pkg::SMIN, pdrc_pkg::SMIN, unit,
             {pdrc_pkg::SMIN, pdrc_pkg::SMAX, pdrc_pkg::SMIN, pdrc_pkg::SMAX});
        send(pdrc_pkg::SMAX, pdrc_pkg::SMIN, unit, persp);
        send(ONE / 1000, 2 * ONE, unit, persp);            // near raised to one
        send(ONE, 10 * ONE, unit, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0),
                                   pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(1099511)});
        send(ONE, 10 * ONE, unit, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0),
                                   pdrc_pkg::t_q'(1099512), pdrc_pkg::t_q'(0)});
        send(ONE, 10 * ONE, unit, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0),
                                   pdrc_pkg::t_q'(-1099511), pdrc_pkg::t_q'(0)});
        // zero plane numerator
        send(ONE, 10 * ONE, zero4, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0),
                                    pdrc_pkg::t_q'(0), ONE});
        // zero plane divisor with a unit column 2
        send(ONE, 10 * ONE, unit, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0),
                                   pdrc_pkg::t_q'(0), ONE});
        send(ONE, 10 * ONE, unit, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0),
                                   pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(ONE * 3)});
        // zero plane divisor
        send(ONE, 10 * ONE, unit, {pdrc_pkg::t_q'(0), pdrc_pkg::t_q'(0), ONE, ONE});
        send(-10 * ONE, -ONE, unit, persp);
        send(0, 0, zero4, zero4);
        send(-1, -1, {pdrc_pkg::SMAX, pdrc_pkg::SMAX, pdrc_pkg::SMAX, pdrc_pkg::SMAX},
             {pdrc_pkg::SMAX, pdrc_pkg::SMAX, pdrc_pkg::SMAX, pdrc_pkg::SMAX});
        drain();

        // open bounds, no ratio floor; sender gaps light
        reg_write(pdrc_pkg::REG_MIN_NEAR, pdrc_pkg::SMIN);
        reg_write(pdrc_pkg::REG_MAX_FAR, pdrc_pkg::SMAX);
        reg_write(pdrc_pkg::REG_RATIO, 64'd0);
        gap_pct = 23;
        random_phase(170);
        drain();

        // tight bounds, largest ratio; heavier gaps
        reg_write(pdrc_pkg::REG_MIN_NEAR, 64'(ONE / 2));
        reg_write(pdrc_pkg::REG_MAX_FAR, 64'(1000 * ONE));
        reg_write(pdrc_pkg::REG_RATIO, 64'h1_FFFF_FFFF_FF);
        gap_pct = 48;
        random_phase(150);
        drain();

        // crossed extreme bounds: every request is rejected
        reg_write(pdrc_pkg::REG_MIN_NEAR, pdrc_pkg::SMAX);
        reg_write(pdrc_pkg::REG_MAX_FAR, pdrc_pkg::SMIN);
        random_phase(20);
        drain();

        // moderate setting, back to back requests
        reg_write(pdrc_pkg::REG_MIN_NEAR, 64'(-100 * ONE));
        reg_write(pdrc_pkg::REG_MAX_FAR, 64'(1) << 62);
        reg_write(pdrc_pkg::REG_RATIO, 64'd164926744);
        gap_pct = 0;
        random_phase(170);
        drain();

        $display("%0d requests sent, %0d results checked, %0d of them rejected ranges",
                 sent, checked, rejected);
        $display("four register settings covered, including open, tight and crossed bounds");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pdrc_pkg.sv
sv/pdrc_mul.sv
sv/pdrc_div.sv
sv/projection_depth_range_clamp.sv
dv/pdrc_checker.sv
dv/tb_projection_depth_range_clamp.sv
